[rtl/core/utn_pkg.sv]
`timescale 1ns / 1ps

package utn_pkg;

    // default buffer depth in bytes
    localparam int MAX_LEN_DEF = 32;

    // utf-8 class masks and codes
    localparam logic [7:0] MASK_2B   = 8'hE0;
    localparam logic [7:0] MASK_CONT = 8'hC0;
    localparam logic [7:0] MASK_3B   = 8'hF0;
    localparam logic [7:0] MASK_4B   = 8'hF8;
    localparam logic [7:0] CODE_CONT = 8'h80;
    localparam logic [7:0] CODE_2B   = 8'hC0;
    localparam logic [7:0] CODE_3B   = 8'hE0;
    localparam logic [7:0] CODE_4B   = 8'hF0;
    localparam logic [7:0] LOW_BITS  = 8'h3F;

    // double-encoded sequence head
    localparam logic [7:0] DBL_B0 = 8'hC3;
    localparam logic [7:0] DBL_B1 = 8'h83;
    localparam logic [7:0] DBL_B2 = 8'hC2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       was_converted;
        logic       overflowed;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic drain;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit_last;
    } ctrl_sts_t;

    // tail bytes that close a double-encoded sequence
    function automatic logic is_repair_tail(input logic [7:0] b);
        logic r;
        case (b) inside
            8'hA9, 8'hA8, 8'hAA, 8'hA0, 8'hB4, 8'hBB, 8'hA7: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/utn_ctrl.sv]
`timescale 1ns / 1ps

module utn_ctrl
    import utn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       in_last,
    input  ctrl_sts_t  sts,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // command decode
    always_comb
    begin
        cmd.load   = start && (state_reg == ST_LOAD);
        cmd.drain  = (state_reg == ST_DRAIN);
        cmd.finish = (state_reg == ST_DRAIN) && sts.emit_last;
        busy       = (state_reg == ST_DRAIN);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (start && in_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.emit_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/utn_datapath.sv]
`timescale 1ns / 1ps

module utn_datapath
    import utn_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  cmd,
    input  item_t      item,
    output ctrl_sts_t  sts,
    output result_t    result,
    output logic       result_strobe
);

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    // text buffer
    logic [7:0] mem [MAX_LEN];

    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [1:0]       pending_reg, pending_next;
    logic             invalid_reg, invalid_next;
    logic             overflow_reg, overflow_next;

    // drain side
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [7:0]       src_reg;
    logic             src_vld_reg, src_vld_next;
    logic             half_reg, half_next;
    logic [7:0]       win_reg [4];
    logic [7:0]       win_next [4];
    logic [2:0]       wcnt_reg, wcnt_next;
    result_t          result_reg, result_next;
    logic             strobe_reg, strobe_next;

    logic             space;
    logic             conv;
    logic             gen_done;
    logic             expand;
    logic [7:0]       tbyte;
    logic             match;
    logic [1:0]       pop;
    logic [2:0]       rem;
    logic             push;
    logic             consume;
    logic             fetch;
    logic             emit_last;

    assign space = (byte_count_reg < CNT_W'(MAX_LEN));
    assign conv  = invalid_reg || (pending_reg != 2'd0);

    // load side: counting and lenient utf-8 check
    always_comb
    begin
        byte_count_next = byte_count_reg;
        pending_next    = pending_reg;
        invalid_next    = invalid_reg;
        overflow_next   = overflow_reg;
        if (cmd.load)
        begin
            if (space)
            begin
                byte_count_next = byte_count_reg + CNT_W'(1);
                if (!invalid_reg)
                begin
                    if (pending_reg != 2'd0)
                    begin
                        if ((item.in_byte & MASK_CONT) != CODE_CONT)
                        begin
                            invalid_next = 1'b1;
                        end
                        else
                        begin
                            pending_next = pending_reg - 2'd1;
                        end
                    end
                    else if (item.in_byte[7])
                    begin
                        if ((item.in_byte & MASK_2B) == CODE_2B)
                        begin
                            pending_next = 2'd1;
                        end
                        else if ((item.in_byte & MASK_3B) == CODE_3B)
                        begin
                            pending_next = 2'd2;
                        end
                        else if ((item.in_byte & MASK_4B) == CODE_4B)
                        begin
                            pending_next = 2'd3;
                        end
                        else
                        begin
                            invalid_next = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
        if (cmd.finish)
        begin
            byte_count_next = '0;
            pending_next    = 2'd0;
            invalid_next    = 1'b0;
            overflow_next   = 1'b0;
        end
    end

    // buffer write
    always_ff @(posedge clk)
    begin
        if (cmd.load && space)
        begin
            mem[byte_count_reg[IDX_W-1:0]] <= item.in_byte;
        end
    end

    // latin-1 expansion of the current source byte
    assign expand   = conv && src_reg[7];
    assign tbyte    = !expand ? src_reg :
                      (!half_reg ? (CODE_2B | {6'd0, src_reg[7:6]})
                                 : (CODE_CONT | (src_reg & LOW_BITS)));
    assign gen_done = !src_vld_reg && (rd_ptr_reg == byte_count_reg);

    // repair window and output selection
    always_comb
    begin
        match = (wcnt_reg == 3'd4) && (win_reg[0] == DBL_B0) && (win_reg[1] == DBL_B1)
                && (win_reg[2] == DBL_B2) && is_repair_tail(win_reg[3]);
        pop = 2'd0;
        if (cmd.drain && (wcnt_reg != 3'd0) && ((wcnt_reg == 3'd4) || gen_done))
        begin
            pop = match ? 2'd3 : 2'd1;
        end
        emit_last = (pop == 2'd1) && gen_done && (wcnt_reg == 3'd1);
        rem  = wcnt_reg - {1'b0, pop};
        push = cmd.drain && src_vld_reg && (rem < 3'd4);
        for (int j = 0; j < 4; j++)
        begin
            win_next[j] = win_reg[j];
        end
        case (pop)
            2'd1:
            begin
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = win_reg[3];
            end
            2'd3:
            begin
                win_next[0] = win_reg[3];
            end
            default: ;
        endcase
        if (push)
        begin
            win_next[rem[1:0]] = tbyte;
        end
        wcnt_next = rem + {2'd0, push};

        consume = push && (!expand || half_reg);
        half_next = half_reg;
        if (consume)
        begin
            half_next = 1'b0;
        end
        else if (push)
        begin
            half_next = 1'b1;
        end

        fetch = cmd.drain && (!src_vld_reg || consume) && (rd_ptr_reg < byte_count_reg);
        rd_ptr_next  = fetch ? rd_ptr_reg + CNT_W'(1) : rd_ptr_reg;
        src_vld_next = fetch ? 1'b1 : (consume ? 1'b0 : src_vld_reg);

        strobe_next               = (pop != 2'd0);
        result_next.out_byte      = win_reg[0];
        result_next.out_last      = emit_last;
        result_next.was_converted = conv;
        result_next.overflowed    = overflow_reg;

        if (cmd.finish)
        begin
            rd_ptr_next  = '0;
            src_vld_next = 1'b0;
            half_next    = 1'b0;
            wcnt_next    = 3'd0;
        end
    end

    assign sts.emit_last = emit_last;

    // buffer read and window payload
    always_ff @(posedge clk)
    begin
        if (fetch)
        begin
            src_reg <= mem[rd_ptr_reg[IDX_W-1:0]];
        end
        for (int j = 0; j < 4; j++)
        begin
            win_reg[j] <= win_next[j];
        end
        result_reg <= result_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            pending_reg    <= 2'd0;
            invalid_reg    <= 1'b0;
            overflow_reg   <= 1'b0;
            rd_ptr_reg     <= '0;
            src_vld_reg    <= 1'b0;
            half_reg       <= 1'b0;
            wcnt_reg       <= 3'd0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            pending_reg    <= pending_next;
            invalid_reg    <= invalid_next;
            overflow_reg   <= overflow_next;
            rd_ptr_reg     <= rd_ptr_next;
            src_vld_reg    <= src_vld_next;
            half_reg       <= half_next;
            wcnt_reg       <= wcnt_next;
            strobe_reg     <= strobe_next;
        end
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule

[rtl/core/utf8_text_normalizer_core.sv]
`timescale 1ns / 1ps

// utf-8 text normalizer
// input channel: a beat (item) is taken on a rising edge with start high and busy low;
// item.in_last marks the final byte of a string. bytes past MAX_LEN are dropped and
// reported through result.overflowed.
// while bytes load, one per cycle, a lenient utf-8 check runs. after the final byte
// busy rises and the buffer drains: invalid strings are expanded as latin-1 into
// two-byte utf-8, and double-encoded c3 83 c2 xx (xx a repair tail) folds to c3 xx.
// output channel: each result beat is on result for one cycle with result_strobe high;
// result.out_last marks the final beat of the string. the receiver cannot stall.
// the first result beat comes once the repair window is full or the string is
// used up; then one beat per cycle, set by the single buffer read port, with an
// idle gap behind each folded sequence while the four-byte repair window refills.
// busy stays high for the drain of the p expanded bytes (p from n to 2n for n stored
// bytes). the final beat is on result in the first cycle with busy low, so the next
// string can start there.
// reset clears the controller and all counters; buffer contents need no clearing.
module utf8_text_normalizer_core
    import utn_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output result_t result,
    output logic    result_strobe
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // sequencing
    utn_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_last (item.in_last),
        .sts     (sts),
        .cmd     (cmd),
        .busy    (busy)
    );

    // buffer, check and repair
    utn_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .item          (item),
        .sts           (sts),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

[test/utf8_text_normalizer_core_tb.sv]
`timescale 1ns / 1ps

module utf8_text_normalizer_core_tb;
    import utn_pkg::*;

    localparam int DEPTH          = MAX_LEN_DEF;
    localparam int RANDOM_ITEMS   = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int MAX_SHOWN      = 10;

    // one directed beat, with up to two hand-typed results on the final byte
    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
        logic [1:0] n_typed;
        result_t    typed0;
        result_t    typed1;
    } dir_row_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    result_t result;
    logic    result_strobe;

    // expected output bytes, oldest first
    result_t expected_bytes [$];
    int      err_count = 0;
    int      quiet_cycles = 0;

    // shadow of the block's string state
    logic [7:0] text_copy [DEPTH];
    int         stored;
    logic [1:0] pending;
    bit         bad_seen;
    bit         ovf_seen;

    // trailing bytes that close a double-encoded sequence
    logic [7:0] fold_tails [7] = '{8'hA9, 8'hA8, 8'hAA, 8'hA0, 8'hB4, 8'hBB, 8'hA7};

    // directed strings: extremes, error classes, multibyte at end, folding
    dir_row_t dir_rows [21] = '{
        // single byte extremes
        '{8'h00, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b0, 1'b0}, '0},
        '{8'h7F, 1'b1, 2'd1, '{8'h7F, 1'b1, 1'b0, 1'b0}, '0},
        // invalid lead byte, expanded as latin-1
        '{8'hFF, 1'b1, 2'd2, '{8'hC3, 1'b0, 1'b1, 1'b0}, '{8'hBF, 1'b1, 1'b1, 1'b0}},
        // stray continuation byte
        '{8'h80, 1'b1, 2'd2, '{8'hC2, 1'b0, 1'b1, 1'b0}, '{8'h80, 1'b1, 1'b1, 1'b0}},
        // two-byte character ending at end of string
        '{8'hC3, 1'b0, 2'd0, '0, '0},
        '{8'hA9, 1'b1, 2'd0, '0, '0},
        // three-byte character
        '{8'hE2, 1'b0, 2'd0, '0, '0},
        '{8'h82, 1'b0, 2'd0, '0, '0},
        '{8'hAC, 1'b1, 2'd0, '0, '0},
        // four-byte character
        '{8'hF0, 1'b0, 2'd0, '0, '0},
        '{8'h9F, 1'b0, 2'd0, '0, '0},
        '{8'h98, 1'b0, 2'd0, '0, '0},
        '{8'h80, 1'b1, 2'd0, '0, '0},
        // double-encoded sequence in valid text
        '{8'hC3, 1'b0, 2'd0, '0, '0},
        '{8'h83, 1'b0, 2'd0, '0, '0},
        '{8'hC2, 1'b0, 2'd0, '0, '0},
        '{8'hA9, 1'b1, 2'd0, '0, '0},
        // lead byte missing its continuation at end of string
        '{8'hE9, 1'b1, 2'd0, '0, '0},
        // latin-1 expansion that creates a double-encoded sequence
        '{8'hFF, 1'b0, 2'd0, '0, '0},
        '{8'hC3, 1'b0, 2'd0, '0, '0},
        '{8'hA9, 1'b1, 2'd0, '0, '0}
    };

    utf8_text_normalizer_core #(
        .MAX_LEN(DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result       (result),
        .result_strobe(result_strobe)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // append one entry at the tail of a queue
    function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] v);
        q.insert(q.size(), v);
    endfunction

    function automatic void add_result(ref result_t q[$], input result_t v);
        q.insert(q.size(), v);
    endfunction

    // take one byte into the shadow state; on the final byte produce the output bytes
    function automatic void normalize_byte(input item_t it, ref result_t outs[$]);
        logic [7:0] wide [$];
        logic [7:0] b;
        bit         conv;
        bit         tail_hit;
        int         i;
        result_t    r;
        outs.delete();
        if (stored < DEPTH)
        begin
            text_copy[stored] = it.in_byte;
            stored++;
            // lenient check: lead classes and required continuations only
            if (!bad_seen)
            begin
                if (pending != 2'd0)
                begin
                    if ((it.in_byte & MASK_CONT) != CODE_CONT)
                        bad_seen = 1'b1;
                    else
                        pending = pending - 2'd1;
                end
                else if (it.in_byte[7])
                begin
                    if ((it.in_byte & MASK_2B) == CODE_2B)
                        pending = 2'd1;
                    else if ((it.in_byte & MASK_3B) == CODE_3B)
                        pending = 2'd2;
                    else if ((it.in_byte & MASK_4B) == CODE_4B)
                        pending = 2'd3;
                    else
                        bad_seen = 1'b1;
                end
            end
        end
        else
            ovf_seen = 1'b1;
        if (!it.in_last)
            return;

        // latin-1 expansion of invalid text
        conv = bad_seen || (pending != 2'd0);
        for (int k = 0; k < stored; k++)
        begin
            b = text_copy[k];
            if (conv && b[7])
            begin
                add_byte(wide, {6'b110000, b[7:6]});
                add_byte(wide, {2'b10, b[5:0]});
            end
            else
                add_byte(wide, b);
        end

        // fold c3 83 c2 xx into c3 xx
        i = 0;
        r.out_last      = 1'b0;
        r.was_converted = conv;
        r.overflowed    = ovf_seen;
        while (i < wide.size())
        begin
            tail_hit = 1'b0;
            if (i + 3 < wide.size())
                foreach (fold_tails[t])
                    if (wide[i + 3] == fold_tails[t])
                        tail_hit = 1'b1;
            if (tail_hit && wide[i] == DBL_B0 && wide[i + 1] == DBL_B1 && wide[i + 2] == DBL_B2)
            begin
                r.out_byte = DBL_B0;
                add_result(outs, r);
                b = wide[i + 3];
                i += 4;
            end
            else
            begin
                b = wide[i];
                i++;
            end
            r.out_byte = b;
            add_result(outs, r);
        end
        r = outs[outs.size() - 1];
        r.out_last = 1'b1;
        outs[outs.size() - 1] = r;

        stored   = 0;
        pending  = 2'd0;
        bad_seen = 1'b0;
        ovf_seen = 1'b0;
    endfunction

    // present one byte, optionally after an idle burst, and wait for it to be taken
    task automatic send_byte(input item_t it, input bit allow_gap, ref result_t outs[$]);
        if (allow_gap && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        normalize_byte(it, outs);
    endtask

    // hold the sender off until every expected byte has come out
    task automatic drain_wait();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_bytes.size() != 0);
    endtask

    // random string: mostly well-formed utf-8 and double-encoded runs, some noise
    task automatic build_string(ref logic [7:0] s[$], input bit long_one);
        int target;
        bit noisy;
        s.delete();
        noisy  = ($urandom_range(0, 9) < 3);
        target = long_one ? $urandom_range(DEPTH - 4, DEPTH + 8) : $urandom_range(1, 10);
        while (s.size() < target)
        begin
            case (noisy ? $urandom_range(0, 6) : $urandom_range(0, 4))
                0: add_byte(s, 8'($urandom_range(0, 127)));
                1:
                begin
                    add_byte(s, 8'($urandom_range(8'hC2, 8'hDF)));
                    add_byte(s, 8'($urandom_range(8'h80, 8'hBF)));
                end
                2:
                begin
                    add_byte(s, 8'($urandom_range(8'hE0, 8'hEF)));
                    repeat (2) add_byte(s, 8'($urandom_range(8'h80, 8'hBF)));
                end
                3:
                begin
                    add_byte(s, 8'($urandom_range(8'hF0, 8'hF7)));
                    repeat (3) add_byte(s, 8'($urandom_range(8'h80, 8'hBF)));
                end
                4:
                begin
                    add_byte(s, DBL_B0);
                    add_byte(s, DBL_B1);
                    add_byte(s, DBL_B2);
                    if ($urandom_range(0, 4) != 0)
                        add_byte(s, fold_tails[$urandom_range(0, 6)]);
                    else
                        add_byte(s, 8'($urandom_range(8'h80, 8'hBF)));
                end
                5: add_byte(s, 8'($urandom_range(8'h80, 8'hFF)));
                default: add_byte(s, 8'($urandom_range(0, 255)));
            endcase
        end
        // noisy strings may cut a character short at the end
        if (noisy)
            while (s.size() > target)
                void'(s.pop_back());
    endtask

    task automatic flag_mismatch(input string what, input result_t want, input result_t got);
        err_count++;
        if (err_count <= MAX_SHOWN)
        begin
            $write("%0t %s: expected byte=%h last=%b conv=%b ovf=%b, ", $realtime, what,
                   want.out_byte, want.out_last, want.was_converted, want.overflowed);
            $display("got byte=%h last=%b conv=%b ovf=%b", got.out_byte, got.out_last,
                     got.was_converted, got.overflowed);
        end
    endtask

    // compare each output beat with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (result_strobe === 1'b1)
        begin
            if (expected_bytes.size() == 0)
                flag_mismatch("unexpected beat", '0, result);
            else
            begin
                want = expected_bytes.pop_front();
                if (result.out_byte !== want.out_byte || result.out_last !== want.out_last ||
                    result.was_converted !== want.was_converted ||
                    result.overflowed !== want.overflowed)
                    flag_mismatch("beat mismatch", want, result);
            end
        end
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start === 1'b1 && busy === 1'b0) || result_strobe === 1'b1)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        result_t    fresh [$];
        logic [7:0] text [$];
        item_t      it;
        int         sent;
        int         strings;
        bit         calm;
        stored       = 0;
        pending      = 2'd0;
        bad_seen     = 1'b0;
        ovf_seen     = 1'b0;
        start <= 1'b0;
        item  <= '0;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[r])
        begin
            it.in_byte = dir_rows[r].text_byte;
            it.in_last = dir_rows[r].final_byte;
            send_byte(it, 1'b1, fresh);
            if (dir_rows[r].n_typed != 2'd0)
            begin
                fresh.delete();
                add_result(fresh, dir_rows[r].typed0);
                if (dir_rows[r].n_typed == 2'd2)
                    add_result(fresh, dir_rows[r].typed1);
            end
            foreach (fresh[k])
                add_result(expected_bytes, fresh[k]);
        end
        drain_wait();

        // random strings, first one long, near or past the buffer depth
        sent    = 0;
        strings = 0;
        while (sent < RANDOM_ITEMS)
        begin
            build_string(text, strings == 0 || $urandom_range(0, 11) == 0);
            foreach (text[k])
            begin
                calm       = (sent >= RANDOM_ITEMS * 4 / 5);
                it.in_byte = text[k];
                it.in_last = (k == text.size() - 1);
                send_byte(it, !calm, fresh);
                foreach (fresh[j])
                    add_result(expected_bytes, fresh[j]);
                sent++;
            end
            if (sent < RANDOM_ITEMS * 4 / 5 && $urandom_range(0, 5) == 0)
                drain_wait();
            strings++;
        end

        // wait out the last string, then watch for stray beats
        drain_wait();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
